@@ hw/rtl/first_fit_bin_packer_assert.svh @@
// Assertion macros used by the RTL file ffbp_scan.sv.
// Both sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef FIRST_FIT_BIN_PACKER_ASSERT_SVH
`define FIRST_FIT_BIN_PACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFBP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffbp assertion failed");
`define FFBP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffbp assertion failed");
`else
`define FFBP_ASSERT_IMP(lbl, ante, cons)
`define FFBP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/ffbp_pkg.sv @@
`timescale 1ns / 1ps
package ffbp_pkg;
	localparam int SZ_W   = 16;
	localparam int IDX_W  = 6;
	localparam int USED_W = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0]  bin_index;
		logic              opened_new;
		logic              oversize;
		logic              no_room;
		logic [USED_W-1:0] bins_used;
	} res_t;
endpackage

@@ hw/rtl/ffbp_if.sv @@
`timescale 1ns / 1ps
interface ffbp_in_if import ffbp_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [SZ_W-1:0] item_size;
	logic            start_instance;

	modport source (output valid, output item_size, output start_instance, input ready);
	modport sink (input valid, input item_size, input start_instance, output ready);
endinterface

interface ffbp_out_if import ffbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  bin_index;
	logic              opened_new;
	logic              oversize;
	logic              no_room;
	logic [USED_W-1:0] bins_used;

	modport source (output valid, output bin_index, output opened_new, output oversize,
		output no_room, output bins_used, input ready);
	modport sink (input valid, input bin_index, input opened_new, input oversize,
		input no_room, input bins_used, output ready);
endinterface

@@ hw/rtl/ffbp_ram.sv @@
`timescale 1ns / 1ps
module ffbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ hw/rtl/ffbp_scan.sv @@
`timescale 1ns / 1ps
`include "first_fit_bin_packer_assert.svh"
module ffbp_scan import ffbp_pkg::*; #(
	parameter int MAX_BINS  = 64,
	parameter int SIZE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	ffbp_in_if.sink         items,
	input  logic [SZ_W-1:0] cap,
	input  logic            res_taken,
	output logic            res_valid,
	output res_t            res
);
	localparam int FW = (SIZE_BITS < SZ_W) ? SIZE_BITS : SZ_W;
	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = $clog2(MAX_BINS + 1);

	state_t          state_q, state_d;
	logic [FW-1:0]   item_q;
	logic            over_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_ptr_q;
	logic            chk_vld_s1;
	logic [AW-1:0]   chk_ptr_s1;
	res_t            res_q;

	logic            accept;
	logic [FW-1:0]   item_w;
	logic [FW-1:0]   cap_w;
	logic [FW-1:0]   rd_data;
	logic [FW:0]     sum;
	logic            fit;
	logic            chk_last;
	logic            hit;
	logic            miss;
	logic            room;
	logic            issue;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [FW-1:0]   ram_wdata;

	assign item_w   = items.item_size[FW-1:0];
	assign cap_w    = cap[FW-1:0];
	assign accept   = items.valid && items.ready;
	assign sum      = {1'b0, rd_data} + {1'b0, item_q};
	assign fit      = sum <= {1'b0, cap_w};
	assign chk_last = (CW'(chk_ptr_s1) + CW'(1)) == count_q;
	assign hit      = (state_q == ST_SCAN) && chk_vld_s1 && fit;
	assign miss     = (state_q == ST_SCAN) &&
		((count_q == '0) || (chk_vld_s1 && !fit && chk_last));
	assign room     = count_q < CW'(MAX_BINS);
	assign issue    = (state_q == ST_SCAN) && (rd_ptr_q < count_q) && !hit && !miss;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || miss) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_taken) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		items.ready = (state_q == ST_IDLE);
		res_valid   = (state_q == ST_DONE);
		res         = res_q;
		ram_we      = hit || (miss && room);
		ram_waddr   = hit ? chk_ptr_s1 : count_q[AW-1:0];
		ram_wdata   = hit ? sum[FW-1:0] : item_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_ptr_q   <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rd_ptr_q   <= '0;
				chk_vld_s1 <= 1'b0;
				if (items.start_instance) begin
					count_q <= '0;
				end
			end else begin
				chk_vld_s1 <= issue;
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
				if (miss && room) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_w;
			over_q <= item_w > cap_w;
		end
		chk_ptr_s1 <= rd_ptr_q[AW-1:0];
		if (hit) begin
			res_q.bin_index  <= IDX_W'(chk_ptr_s1);
			res_q.opened_new <= 1'b0;
			res_q.oversize   <= over_q;
			res_q.no_room    <= 1'b0;
			res_q.bins_used  <= USED_W'(count_q);
		end else if (miss && room) begin
			res_q.bin_index  <= IDX_W'(count_q);
			res_q.opened_new <= 1'b1;
			res_q.oversize   <= over_q;
			res_q.no_room    <= 1'b0;
			res_q.bins_used  <= USED_W'(count_q + CW'(1));
		end else if (miss) begin
			res_q.bin_index  <= '0;
			res_q.opened_new <= 1'b0;
			res_q.oversize   <= over_q;
			res_q.no_room    <= 1'b1;
			res_q.bins_used  <= USED_W'(count_q);
		end
	end

	ffbp_ram #(
		.WIDTH(FW),
		.DEPTH(MAX_BINS)
	) u_fill_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(rd_data)
	);

	`FFBP_ASSERT_IMP(a_count_max, 1'b1, count_q <= CW'(MAX_BINS))
	`FFBP_ASSERT_IMP(a_ptr_bound, state_q == ST_SCAN, rd_ptr_q <= count_q)
	`FFBP_ASSERT_IMP(a_we_scan, ram_we, state_q == ST_SCAN)
	`FFBP_ASSERT_NXT(a_accept_scan, accept, state_q == ST_SCAN)
	`FFBP_ASSERT_IMP(a_full_closed, res_valid && res_q.no_room,
		!res_q.opened_new && (count_q == CW'(MAX_BINS)))
endmodule

@@ hw/rtl/first_fit_bin_packer.sv @@
`timescale 1ns / 1ps
// After a transaction is accepted, the open bins are scanned in order until one fits or none is left;
// the scan reads one bin fill per cycle from the fill memory; results pass through the output register.
// One item is worked on at a time; a new transaction waits until the last result is taken by the output register.
// The next item is accepted while the last result waits in the output register.
// Reset clears the open bin count and sets the capacity to 65535; the fill memory is not cleared.
module first_fit_bin_packer import ffbp_pkg::*; #(
	parameter int MAX_BINS  = 64,
	parameter int SIZE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [SZ_W-1:0] cfg_wr_data,
	ffbp_in_if.sink         items,
	ffbp_out_if.source      results
);
	logic [SZ_W-1:0] cap_q;
	logic            out_vld_q;
	res_t            out_res_q;
	logic            res_valid;
	logic            res_taken;
	res_t            res;

	assign res_taken = !out_vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= '1;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (res_taken) begin
				out_vld_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken && res_valid) begin
			out_res_q <= res;
		end
	end

	assign results.valid      = out_vld_q;
	assign results.bin_index  = out_res_q.bin_index;
	assign results.opened_new = out_res_q.opened_new;
	assign results.oversize   = out_res_q.oversize;
	assign results.no_room    = out_res_q.no_room;
	assign results.bins_used  = out_res_q.bins_used;

	ffbp_scan #(
		.MAX_BINS (MAX_BINS),
		.SIZE_BITS(SIZE_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.cap      (cap_q),
		.res_taken(res_taken),
		.res_valid(res_valid),
		.res      (res)
	);
endmodule

@@ tb/ffbp_placement_checker.sv @@
`timescale 1ns / 1ps
module ffbp_placement_checker import ffbp_pkg::*; #(
	parameter int MAX_BINS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [SZ_W-1:0] cfg_wr_data,
	ffbp_in_if              items,
	ffbp_out_if             results,
	output int              errors,
	output int              outstanding,
	output int              results_seen,
	output int              new_bins,
	output int              oversize_seen,
	output int              full_seen
);
	localparam int PRINT_LIMIT = 40;

	logic [SZ_W-1:0] capacity;
	logic [SZ_W-1:0] fill_level [MAX_BINS];
	int              open_bins;
	res_t            expected_placements [$];

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_LIMIT) begin
			$display("[%0t] placement error: %s", $realtime, msg);
		end
		errors++;
	endtask

	task automatic compare_field(input string field, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_seen, field, got, want));
		end
	endtask

	function automatic res_t place_item(input logic [SZ_W-1:0] size, input logic fresh);
		res_t r;
		int   slot;
		r = '0;
		slot = -1;
		r.oversize = size > capacity;
		if (fresh) begin
			open_bins = 0;
		end
		for (int k = 0; k < open_bins; k++) begin
			if (slot < 0 && ({1'b0, fill_level[k]} + {1'b0, size}) <= {1'b0, capacity}) begin
				slot = k;
			end
		end
		if (slot >= 0) begin
			fill_level[slot] = fill_level[slot] + size;
			r.bin_index = IDX_W'(slot);
		end else if (open_bins < MAX_BINS) begin
			fill_level[open_bins] = size;
			r.bin_index = IDX_W'(open_bins);
			r.opened_new = 1'b1;
			open_bins++;
		end else begin
			r.no_room = 1'b1;
		end
		r.bins_used = USED_W'(open_bins);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			capacity = 16'hFFFF;
			open_bins = 0;
			expected_placements.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				capacity = cfg_wr_data;
			end
			if (results.valid && results.ready) begin
				if (expected_placements.size() == 0) begin
					report_mismatch($sformatf("unexpected result with bin_index %0d",
						results.bin_index));
				end else begin
					want = expected_placements.pop_front();
					compare_field("bin_index", results.bin_index, want.bin_index);
					compare_field("opened_new", results.opened_new, want.opened_new);
					compare_field("oversize", results.oversize, want.oversize);
					compare_field("no_room", results.no_room, want.no_room);
					compare_field("bins_used", results.bins_used, want.bins_used);
					new_bins += want.opened_new;
					oversize_seen += want.oversize;
					full_seen += want.no_room;
				end
				results_seen++;
			end
			if (items.valid && items.ready) begin
				expected_placements.insert(expected_placements.size(),
					place_item(items.item_size, items.start_instance));
			end
			outstanding <= expected_placements.size();
		end
	end
endmodule

@@ tb/first_fit_bin_packer_tb.sv @@
`timescale 1ns / 1ps
module first_fit_bin_packer_tb;
	import ffbp_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 80;

	typedef enum int {
		SEQ_PLAIN,
		SEQ_FILL,
		SEQ_NOISE
	} seq_kind_e;

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [SZ_W-1:0] cfg_wr_data;

	ffbp_in_if  item_ch();
	ffbp_out_if result_ch();

	int              errors;
	int              outstanding;
	int              results_seen;
	int              new_bins;
	int              oversize_seen;
	int              full_seen;
	int              send_idle_pct;
	int              recv_idle_pct;
	int              cycle_count;
	int              capacity_writes;
	logic            hold_req;
	logic [SZ_W-1:0] bin_capacity;

	first_fit_bin_packer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.items       (item_ch),
		.results     (result_ch)
	);

	ffbp_placement_checker packing_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.items         (item_ch),
		.results       (result_ch),
		.errors        (errors),
		.outstanding   (outstanding),
		.results_seen  (results_seen),
		.new_bins      (new_bins),
		.oversize_seen (oversize_seen),
		.full_seen     (full_seen)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, outstanding);
			$display("Test completed with failures");
			$finish;
		end
	end

	// The receiver honors a hold request once by keeping ready low for a long stretch.
	initial begin
		int held;
		bit hold_done;
		hold_done = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					@(posedge clk);
				end
				hold_done = 1'b1;
			end
			result_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input logic [SZ_W-1:0] size, input logic fresh);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.item_size <= size;
		item_ch.start_instance <= fresh;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_capacity(input logic [SZ_W-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		bin_capacity = value;
		capacity_writes++;
	endtask

	task automatic run_random(input int count);
		int              sent;
		int              len;
		int              cap;
		seq_kind_e       kind;
		logic [SZ_W-1:0] size;
		logic            fresh;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(5))
					0: write_capacity(16'd1);
					1: write_capacity(16'd0);
					2: write_capacity(16'hFFFF);
					3: write_capacity(SZ_W'($urandom_range(2, 300)));
					4: write_capacity(SZ_W'($urandom_range(1000, 40000)));
					default: write_capacity(SZ_W'($urandom()));
				endcase
			end
			cap = int'(bin_capacity);
			len = $urandom_range(99);
			kind = (len < 60) ? SEQ_PLAIN : (len < 80) ? SEQ_FILL : SEQ_NOISE;
			case (kind)
				SEQ_PLAIN: len = $urandom_range(1, 40);
				SEQ_FILL:  len = $urandom_range(66, 90);
				default:   len = $urandom_range(1, 30);
			endcase
			for (int k = 0; k < len; k++) begin
				case (kind)
					SEQ_PLAIN: begin
						fresh = (k == 0) || ($urandom_range(49) == 0);
						case ($urandom_range(9))
							0, 1, 2, 3, 4, 5, 6: size = SZ_W'($urandom_range(0, cap));
							7, 8: size = SZ_W'($urandom_range(0, cap / 8));
							default: size = SZ_W'($urandom_range(cap, 16'hFFFF));
						endcase
					end
					SEQ_FILL: begin
						// Every item takes more than half a bin, so the table fills up.
						fresh = (k == 0);
						size = SZ_W'($urandom_range(cap / 2 + 1, cap));
					end
					default: begin
						fresh = ($urandom_range(9) == 0);
						size = SZ_W'($urandom());
					end
				endcase
				send_item(size, fresh);
				sent++;
			end
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.item_size = '0;
		item_ch.start_instance = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		hold_req = 1'b0;
		bin_capacity = 16'hFFFF;
		send_idle_pct = 24;
		recv_idle_pct = 84;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_item(16'd0, 1'b1);
		send_item(16'hFFFF, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h8000, 1'b1);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h5555, 1'b0);
		send_item(16'hAAAA, 1'b0);
		write_capacity(16'd100);
		send_item(16'd101, 1'b1);
		send_item(16'd100, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'd50, 1'b0);
		write_capacity(16'd0);
		send_item(16'd0, 1'b1);
		send_item(16'd1, 1'b0);
		send_item(16'd0, 1'b0);
		write_capacity(16'd1);
		send_item(16'd1, 1'b1);
		send_item(16'd1, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd2, 1'b0);

		run_random(334);
		send_idle_pct = 84;
		recv_idle_pct = 24;
		run_random(333);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		run_random(333);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d placements under %0d capacity writes; %0d bins were opened.",
			results_seen, capacity_writes, new_bins);
		$display("Saw %0d oversize items and %0d rejections on a full bin table.",
			oversize_seen, full_seen);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ffbp_pkg.sv
hw/rtl/ffbp_if.sv
hw/rtl/ffbp_ram.sv
hw/rtl/ffbp_scan.sv
hw/rtl/first_fit_bin_packer.sv
tb/ffbp_placement_checker.sv
tb/first_fit_bin_packer_tb.sv
